// File: src/pvcd_pkg.sv
// types, command codes and constants shared by the pi velocity controller modules
// no dependencies
`default_nettype none

package pvcd_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;
  localparam int STATE_W    = 24;
  localparam int ERR_W      = 25;
  localparam int MUL_A_W    = 18;

  localparam logic [15:0] RST_SPEED_REF = 16'd2048;
  localparam logic [15:0] RST_ALPHA     = 16'd55706;
  localparam logic [15:0] RST_PERIOD    = 16'd1311;
  localparam logic [17:0] RST_EG        = 18'd1978;
  localparam logic [17:0] RST_IG        = 18'd3956;
  localparam logic [15:0] RST_FF        = 16'd17512;
  localparam logic [22:0] RST_LIMIT     = 23'd1310720;
  localparam logic [14:0] RST_START     = 15'd18022;

  // stop band: |ref| < 0.10 and |filtered| < 0.20
  localparam logic signed [15:0] STOP_REF_MAX = 16'sd25;
  localparam logic signed [23:0] STOP_SPD_MAX = 24'sd13107;
  // small integral cleared in stop band
  localparam logic signed [23:0] SMALL_INT_MAX = 24'sd32767;
  localparam logic signed [15:0] DUTY_MAX = 16'sd32767;

  typedef enum logic [2:0] {
    CFG_SPEED_REF,
    CFG_ALPHA,
    CFG_PERIOD,
    CFG_EG,
    CFG_IG,
    CFG_FF,
    CFG_LIMIT,
    CFG_START
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MUL_ALPHA_F,
    MUL_BETA_M,
    MUL_PER_E,
    MUL_EG_E,
    MUL_IG_I,
    MUL_LIFT
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_R16,
    ACC_ADD_SH8,
    ACC_LOAD_R17,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic        load_in;
    mul_sel_t    mul_sel;
    acc_op_t     acc_op;
    logic        upd_filter;
    logic        upd_integral;
    logic        upd_command;
    logic        load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic signed [15:0] speed_reference;
    logic        [15:0] filter_alpha;
    logic        [15:0] sample_period;
    logic signed [17:0] error_gain;
    logic signed [17:0] integral_gain;
    logic signed [15:0] feedforward;
    logic        [22:0] integral_limit;
    logic        [14:0] deadzone_start;
  } cfg_t;

endpackage

`default_nettype wire

// File: src/pi_velocity_controller_deadzone.sv
// pi velocity controller with anti-windup and motor dead-zone lift
// a new beat is taken only once the last has reached the output register, as all steps share a single multiplier
// the output register lets a new beat enter while the last result waits
// reset: synchronous active low, clears filter and integral, loads config defaults
// depends on pvcd_pkg, pvcd_cfg, pvcd_ctrl, pvcd_dp
`default_nettype none

module pi_velocity_controller_deadzone import pvcd_pkg::*; #(
  parameter int SPEED_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SPEED_WIDTH-1:0] in_raw_speed,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            out_motor_duty,
  output logic signed [STATE_W-1:0]     out_filtered_speed,
  output logic signed [STATE_W-1:0]     out_integral_error,
  output logic                          out_stop_active,
  input  logic                          cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  cfg_t    cfg;
  dp_cmd_t cmd;

  pvcd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pvcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  pvcd_dp #(
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg            (cfg),
    .raw_speed      (in_raw_speed),
    .motor_duty     (out_motor_duty),
    .filtered_speed (out_filtered_speed),
    .integral_error (out_integral_error),
    .stop_active    (out_stop_active)
  );

endmodule

`default_nettype wire

// File: src/pvcd_cfg.sv
// configuration register file with reset defaults
// depends on pvcd_pkg
`default_nettype none

module pvcd_cfg import pvcd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SPEED_REF: cfg_nxt.speed_reference = cfg_wdata[15:0];
        CFG_ALPHA:     cfg_nxt.filter_alpha    = cfg_wdata[15:0];
        CFG_PERIOD:    cfg_nxt.sample_period   = cfg_wdata[15:0];
        CFG_EG:        cfg_nxt.error_gain      = cfg_wdata[17:0];
        CFG_IG:        cfg_nxt.integral_gain   = cfg_wdata[17:0];
        CFG_FF:        cfg_nxt.feedforward     = cfg_wdata[15:0];
        CFG_LIMIT:     cfg_nxt.integral_limit  = cfg_wdata[22:0];
        CFG_START:     cfg_nxt.deadzone_start  = cfg_wdata[14:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_reference <= RST_SPEED_REF;
      cfg_r.filter_alpha    <= RST_ALPHA;
      cfg_r.sample_period   <= RST_PERIOD;
      cfg_r.error_gain      <= RST_EG;
      cfg_r.integral_gain   <= RST_IG;
      cfg_r.feedforward     <= RST_FF;
      cfg_r.integral_limit  <= RST_LIMIT;
      cfg_r.deadzone_start  <= RST_START;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: src/pvcd_ctrl.sv
// sequencer for the controller: steps the shared multiplier and accumulator
// depends on pvcd_pkg
`default_nettype none

module pvcd_ctrl import pvcd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_ACC1,
    S_FILT,
    S_MUL3,
    S_INTG,
    S_MUL4,
    S_SUMC,
    S_CMD,
    S_LIFT,
    S_DUTY
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd              = '0;
    cmd.mul_sel      = MUL_ALPHA_F;
    cmd.acc_op       = ACC_HOLD;
    state_nxt        = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul_sel = MUL_ALPHA_F;
        state_nxt   = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_sel = MUL_BETA_M;
        cmd.acc_op  = ACC_LOAD_R16;
        state_nxt   = S_ACC1;
      end
      S_ACC1: begin
        cmd.acc_op = ACC_ADD_SH8;
        state_nxt  = S_FILT;
      end
      S_FILT: begin
        cmd.upd_filter = 1'b1;
        state_nxt      = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul_sel = MUL_PER_E;
        state_nxt   = S_INTG;
      end
      S_INTG: begin
        cmd.upd_integral = 1'b1;
        cmd.mul_sel      = MUL_EG_E;
        state_nxt        = S_MUL4;
      end
      S_MUL4: begin
        cmd.mul_sel = MUL_IG_I;
        cmd.acc_op  = ACC_LOAD_R17;
        state_nxt   = S_SUMC;
      end
      S_SUMC: begin
        cmd.acc_op = ACC_ADD;
        state_nxt  = S_CMD;
      end
      S_CMD: begin
        cmd.upd_command = 1'b1;
        state_nxt       = S_LIFT;
      end
      S_LIFT: begin
        cmd.mul_sel = MUL_LIFT;
        state_nxt   = S_DUTY;
      end
      S_DUTY: begin
        // keep the lift product while the result register is busy
        cmd.mul_sel = MUL_LIFT;
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: src/pvcd_dp.sv
// datapath: shared multiplier, accumulator, filter, integral, command and duty lift
// depends on pvcd_pkg
`default_nettype none

module pvcd_dp import pvcd_pkg::*; #(
  parameter int SPEED_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dp_cmd_t                       cmd,
  input  cfg_t                          cfg,
  input  logic signed [SPEED_WIDTH-1:0] raw_speed,
  output logic signed [15:0]            motor_duty,
  output logic signed [STATE_W-1:0]     filtered_speed,
  output logic signed [STATE_W-1:0]     integral_error,
  output logic                          stop_active
);

  localparam int MUL_B_W = (SPEED_WIDTH + 1 > ERR_W) ? SPEED_WIDTH + 1 : ERR_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 9;

  logic signed [SPEED_WIDTH:0]   neg_speed_r;
  logic signed [STATE_W-1:0]     filt_r;
  logic signed [STATE_W-1:0]     integ_r;
  logic signed [STATE_W-1:0]     integ_pre_r;
  logic signed [ERR_W-1:0]       err_r;
  logic                          stop_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;
  logic                          u_neg_r, u_zero_r;
  logic [14:0]                   mag_r;
  logic signed [15:0]            duty_r;
  logic signed [STATE_W-1:0]     out_filt_r, out_integ_r;
  logic                          out_stop_r;

  logic signed [MUL_A_W-1:0]     mul_a;
  logic signed [MUL_B_W-1:0]     mul_b;
  logic signed [ACC_W-1:0]       prod_ext;

  // filter step
  logic signed [ACC_W-1:0]       filt_wide;
  logic [ACC_W-24:0]             filt_top;
  logic signed [STATE_W-1:0]     filt_sat;
  logic signed [ERR_W-1:0]       err;
  logic                          stop;

  // integral step
  logic signed [PROD_W-1:0]      integ_inc;
  logic signed [PROD_W-1:0]      integ_sum;
  logic signed [PROD_W-1:0]      lim_pos, lim_neg;
  logic signed [STATE_W-1:0]     integ_clamp;

  // command step
  logic signed [ACC_W-1:0]       u_wide;
  logic signed [15:0]            u_sat;
  logic                          small_int;
  logic signed [STATE_W-1:0]     integ_final;

  // duty lift
  logic signed [PROD_W-1:0]      lift;
  logic [16:0]                   duty_sum;
  logic [14:0]                   duty_mag;
  logic signed [15:0]            duty;

  always_comb begin
    case (cmd.mul_sel)
      MUL_ALPHA_F: begin
        mul_a = {2'b00, cfg.filter_alpha};
        mul_b = MUL_B_W'(filt_r);
      end
      MUL_BETA_M: begin
        mul_a = 18'h10000 - {2'b00, cfg.filter_alpha};
        mul_b = MUL_B_W'(neg_speed_r);
      end
      MUL_PER_E: begin
        mul_a = {2'b00, cfg.sample_period};
        mul_b = MUL_B_W'(err_r);
      end
      MUL_EG_E: begin
        mul_a = cfg.error_gain;
        mul_b = MUL_B_W'(err_r);
      end
      MUL_IG_I: begin
        mul_a = cfg.integral_gain;
        mul_b = MUL_B_W'(integ_pre_r);
      end
      MUL_LIFT: begin
        mul_a = 18'h08000 - {3'b000, cfg.deadzone_start};
        mul_b = MUL_B_W'(mag_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_ext = ACC_W'(prod_r);

  always_comb begin
    case (cmd.acc_op)
      ACC_LOAD_R16: acc_nxt = prod_ext + ACC_W'(32'sd32768);
      ACC_ADD_SH8:  acc_nxt = acc_r + (prod_ext <<< 8);
      ACC_LOAD_R17: acc_nxt = prod_ext + ACC_W'(32'sd65536);
      ACC_ADD:      acc_nxt = acc_r + prod_ext;
      default:      acc_nxt = acc_r;
    endcase
  end

  // filter output, saturated to 24 bits, error and stop band flag
  always_comb begin
    filt_wide = acc_r >>> 16;
    filt_top  = filt_wide[ACC_W-1:STATE_W-1];
    if ((&filt_top) || !(|filt_top)) begin
      filt_sat = filt_wide[STATE_W-1:0];
    end else if (filt_wide[ACC_W-1]) begin
      filt_sat = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      filt_sat = {1'b0, {(STATE_W-1){1'b1}}};
    end
    err  = {cfg.speed_reference[15], cfg.speed_reference, 8'h00}
         - {filt_sat[STATE_W-1], filt_sat};
    stop = (cfg.speed_reference <= STOP_REF_MAX) && (cfg.speed_reference >= -STOP_REF_MAX)
        && (filt_sat <= STOP_SPD_MAX) && (filt_sat >= -STOP_SPD_MAX);
  end

  // integral with clamp
  always_comb begin
    integ_inc = (prod_r + PROD_W'(32'sd32768)) >>> 16;
    integ_sum = integ_inc + PROD_W'(integ_r);
    lim_pos   = PROD_W'($signed({1'b0, cfg.integral_limit}));
    lim_neg   = -lim_pos;
    if (integ_sum > lim_pos) begin
      integ_clamp = lim_pos[STATE_W-1:0];
    end else if (integ_sum < lim_neg) begin
      integ_clamp = lim_neg[STATE_W-1:0];
    end else begin
      integ_clamp = integ_sum[STATE_W-1:0];
    end
  end

  // command, clamped to full scale, and small integral cleared in the stop band
  always_comb begin
    u_wide = (acc_r >>> 17) + ACC_W'(cfg.feedforward);
    if (u_wide > ACC_W'(DUTY_MAX)) begin
      u_sat = DUTY_MAX;
    end else if (u_wide < -ACC_W'(DUTY_MAX)) begin
      u_sat = -DUTY_MAX;
    end else begin
      u_sat = u_wide[15:0];
    end
    small_int   = (integ_pre_r <= SMALL_INT_MAX) && (integ_pre_r >= -SMALL_INT_MAX);
    integ_final = (stop_r && small_int) ? '0 : integ_pre_r;
  end

  // dead-zone lift
  always_comb begin
    lift     = (prod_r + PROD_W'(32'sd16384)) >>> 15;
    duty_sum = {2'b00, cfg.deadzone_start} + lift[16:0];
    duty_mag = (duty_sum > 17'd32767) ? 15'h7fff : duty_sum[14:0];
    if (u_zero_r) begin
      duty = '0;
    end else if (u_neg_r) begin
      duty = -$signed({1'b0, duty_mag});
    end else begin
      duty = $signed({1'b0, duty_mag});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r  <= '0;
      integ_r <= '0;
    end else begin
      if (cmd.upd_filter) begin
        filt_r <= filt_sat;
      end
      if (cmd.upd_command) begin
        integ_r <= integ_final;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    acc_r  <= acc_nxt;
    if (cmd.load_in) begin
      neg_speed_r <= (SPEED_WIDTH + 1)'(0) - {raw_speed[SPEED_WIDTH-1], raw_speed};
    end
    if (cmd.upd_filter) begin
      err_r  <= err;
      stop_r <= stop;
    end
    if (cmd.upd_integral) begin
      integ_pre_r <= integ_clamp;
    end
    if (cmd.upd_command) begin
      u_zero_r <= stop_r || (u_sat == 16'sd0);
      u_neg_r  <= u_sat[15];
      mag_r    <= u_sat[15] ? 15'(-u_sat) : u_sat[14:0];
    end
    if (cmd.load_out) begin
      duty_r      <= duty;
      out_filt_r  <= filt_r;
      out_integ_r <= integ_r;
      out_stop_r  <= stop_r;
    end
  end

  assign motor_duty     = duty_r;
  assign filtered_speed = out_filt_r;
  assign integral_error = out_integ_r;
  assign stop_active    = out_stop_r;

endmodule

`default_nettype wire

// File: src/pvcd_checker.sv
// port-level checks for the pi velocity controller, bound to the top level
// depends on pi_velocity_controller_deadzone
`default_nettype none

module pvcd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_motor_duty,
  input logic signed [23:0] out_filtered_speed,
  input logic signed [23:0] out_integral_error,
  input logic               out_stop_active
);

  // stalled result beat holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_motor_duty)
      && $stable(out_filtered_speed) && $stable(out_integral_error)
      && $stable(out_stop_active))
    else $error("stalled result changed");

  // stop band forces a zero duty
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stop_active |-> out_motor_duty == 16'sd0)
    else $error("nonzero duty in stop band");

  // duty stays within plus or minus full scale
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_motor_duty != 16'h8000)
    else $error("duty out of range");

  // an accepted beat keeps the block busy for the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken back to back");

  // no result right after reset
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pi_velocity_controller_deadzone pvcd_checker u_pvcd_checker (.*);

`default_nettype wire
